// ===== rtl/core/iee_pkg.sv =====
// Package: shared types, codes and constants of the infix expression evaluator
package iee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] CMD_NUMBER = 2'd0;
    localparam logic [1:0] CMD_OPER   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_OPEN  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_PAREN    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE_RD,
        S_REDUCE_EX,
        S_DIV_WAIT,
        S_REDUCE_WB,
        S_FINISH,
        S_END_RD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        G_ADDSUB,
        G_MULDIV,
        G_CLOSE,
        G_END
    } goal_t;

    typedef struct packed {
        logic            push_num;
        logic            push_op;
        logic [2:0]      op_val;
        logic            pop_op;
        logic            rd_vals;
        logic            start_ex;
        logic            write_res;
        logic            rd_bottom;
        logic            clear;
        logic            set_err;
        logic [2:0]      err_code;
    } iee_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] value_count;
        logic [CNT_W-1:0] oper_count;
        logic [2:0]       top_op;
        logic [2:0]       error_code;
        logic             ex_done;
        logic             div_zero;
    } iee_stat_t;

endpackage

// ===== rtl/core/infix_expression_evaluator.sv =====
// Top level: two-stack infix expression evaluator
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | cmd, number, op_code
//  out     | out_valid | out_stall | result, status
//
// A number or open paren is taken in the idle state; an operator first reduces the stack,
// each reduction reading, executing, waiting on the one-bit-a-cycle divider for a divide and
// writing back. End of expression then loads the result. Reset clears both stacks and the error.
// The result register holds one request; a new end token waits until it drains.
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] number,
    input  logic [2:0]         op_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result,
    output logic [2:0]         status
);

    iee_cmd_t    dcmd;
    iee_stat_t   stat;
    logic [31:0] bottom;
    logic        out_load;
    logic [31:0] result_reg;
    logic [2:0]  status_reg;

    iee_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_in    (cmd),
        .op_code   (op_code),
        .stat      (stat),
        .cmd       (dcmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_load  (out_load)
    );

    iee_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dcmd),
        .number  (number),
        .stat    (stat),
        .bottom  (bottom)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= stat.error_code;
            result_reg <= (stat.error_code == ST_OK) ? bottom : 32'd0;
        end
    end

    assign result = result_reg;
    assign status = status_reg;

endmodule

// ===== rtl/core/iee_divider.sv =====
// Divider: signed 32-bit restoring division, one quotient bit per cycle
module iee_divider
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    assign shifted = {rem_reg[30:0], quo_reg[31]};
    assign trial   = {1'b0, shifted} - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (~dividend + 32'd1) : dividend;
            den_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;

endmodule

// ===== rtl/core/iee_datapath.sv =====
// Datapath: value and operator stacks, arithmetic unit and error register
module iee_datapath
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iee_cmd_t    cmd,
    input  logic [31:0] number,
    output iee_stat_t   stat,
    output logic [31:0] bottom
);

    logic [31:0] value_mem [STACK_DEPTH];
    logic [2:0]  oper_mem  [STACK_DEPTH];

    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic [2:0]       err_reg, err_next;
    logic [2:0]       top_reg;
    logic [31:0]      right_reg, left_reg, res_reg, bottom_reg;
    logic [2:0]       exop_reg;
    logic [31:0]      prod_w;
    logic             div_start, div_done;
    logic [31:0]      quot;
    logic [CNT_W-1:0] vaddr_r, vaddr_l, vaddr_w;
    logic [CNT_W-1:0] oaddr_r;
    logic [31:0]      vwdata;
    logic             vwen;
    logic [CNT_W-1:0] top_idx;

    assign vaddr_r = vcnt_reg - CNT_W'(1);
    assign vaddr_l = vcnt_reg - CNT_W'(2);
    assign top_idx = ocnt_next - CNT_W'(1);
    assign oaddr_r = top_idx;
    assign prod_w  = left_reg * right_reg;
    assign div_start = cmd.start_ex && (exop_reg == OP_DIV) && (right_reg != 32'd0);

    iee_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_reg),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        err_next  = err_reg;
        vwen      = 1'b0;
        vwdata    = number;
        vaddr_w   = vcnt_reg;
        if (cmd.clear)
        begin
            vcnt_next = '0;
            ocnt_next = '0;
            err_next  = ST_OK;
        end
        else
        begin
            if (cmd.push_num)
            begin
                vwen      = 1'b1;
                vcnt_next = vcnt_reg + CNT_W'(1);
            end
            if (cmd.push_op)
                ocnt_next = ocnt_reg + CNT_W'(1);
            if (cmd.pop_op)
                ocnt_next = ocnt_reg - CNT_W'(1);
            if (cmd.rd_vals)
                vcnt_next = vcnt_reg - CNT_W'(2);
            if (cmd.write_res)
            begin
                vwen      = 1'b1;
                vwdata    = (exop_reg == OP_DIV) ? quot : res_reg;
                vcnt_next = vcnt_reg + CNT_W'(1);
            end
            if (cmd.set_err && err_reg == ST_OK)
                err_next = cmd.err_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
            ocnt_reg <= '0;
            err_reg  <= ST_OK;
        end
        else
        begin
            vcnt_reg <= vcnt_next;
            ocnt_reg <= ocnt_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwen)
            value_mem[vaddr_w[PTR_W-1:0]] <= vwdata;
        if (cmd.push_op)
            oper_mem[ocnt_reg[PTR_W-1:0]] <= cmd.op_val;
        top_reg <= (cmd.push_op) ? cmd.op_val : oper_mem[oaddr_r[PTR_W-1:0]];
        if (cmd.rd_vals)
        begin
            right_reg <= value_mem[vaddr_r[PTR_W-1:0]];
            left_reg  <= value_mem[vaddr_l[PTR_W-1:0]];
            exop_reg  <= top_reg;
        end
        if (cmd.start_ex)
        begin
            unique case (exop_reg)
                OP_ADD:  res_reg <= left_reg + right_reg;
                OP_SUB:  res_reg <= left_reg - right_reg;
                default: res_reg <= prod_w;
            endcase
        end
        if (cmd.rd_bottom)
            bottom_reg <= value_mem[0];
    end

    assign stat.value_count = vcnt_reg;
    assign stat.oper_count  = ocnt_reg;
    assign stat.top_op      = top_reg;
    assign stat.error_code  = err_reg;
    assign stat.ex_done     = div_done || (exop_reg != OP_DIV);
    assign stat.div_zero    = (exop_reg == OP_DIV) && (right_reg == 32'd0);
    assign bottom           = bottom_reg;

endmodule

// ===== rtl/core/iee_control.sv =====
// Controller: token sequencing, reduction loop and result handshake
module iee_control
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd_in,
    input  logic [2:0]  op_code,
    input  iee_stat_t   stat,
    output iee_cmd_t    cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_load
);

    state_t state_reg, state_next;
    goal_t  goal_reg, goal_next;
    logic [2:0] pend_reg, pend_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;
    logic       err;
    logic       op_full, val_full;
    logic       keep_reducing;

    assign in_stall  = (state_reg != S_IDLE) || (ovalid_reg && in_valid && cmd_in == CMD_END);
    assign accept    = in_valid && !in_stall;
    assign err       = stat.error_code != ST_OK;
    assign op_full   = stat.oper_count  == CNT_W'(STACK_DEPTH);
    assign val_full  = stat.value_count == CNT_W'(STACK_DEPTH);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        keep_reducing = 1'b0;
        if (stat.oper_count != '0)
        begin
            unique case (goal_reg)
                G_ADDSUB: keep_reducing = stat.top_op <= OP_DIV;
                G_MULDIV: keep_reducing = stat.top_op == OP_MUL || stat.top_op == OP_DIV;
                G_CLOSE:  keep_reducing = stat.top_op != OP_OPEN;
                default:  keep_reducing = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        goal_next  = goal_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_in == CMD_OPER && !err)
                begin
                    pend_next = op_code;
                    if (op_code == OP_ADD || op_code == OP_SUB)
                    begin
                        goal_next  = G_ADDSUB;
                        state_next = S_FINISH;
                    end
                    else if (op_code == OP_MUL || op_code == OP_DIV)
                    begin
                        goal_next  = G_MULDIV;
                        state_next = S_FINISH;
                    end
                    else if (op_code == OP_CLOSE)
                    begin
                        goal_next  = G_CLOSE;
                        state_next = S_FINISH;
                    end
                end
                else if (accept && cmd_in == CMD_END)
                begin
                    goal_next  = G_END;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!err && keep_reducing)
                begin
                    if (goal_reg == G_END && stat.top_op == OP_OPEN)
                        state_next = S_FINISH;
                    else
                        state_next = S_REDUCE_RD;
                end
                else if (goal_reg == G_END)
                    state_next = S_END_RD;
                else
                    state_next = S_IDLE;
            end
            S_REDUCE_RD:
                state_next = (stat.value_count < CNT_W'(2)) ? S_FINISH : S_REDUCE_EX;
            S_REDUCE_EX:
                state_next = stat.div_zero ? S_FINISH : S_DIV_WAIT;
            S_DIV_WAIT:
                state_next = stat.ex_done ? S_REDUCE_WB : S_DIV_WAIT;
            S_REDUCE_WB:
                state_next = S_FINISH;
            S_END_RD:
                state_next = S_OUT;
            S_OUT:
                state_next = ovalid_reg ? S_OUT : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        ovalid_next = ovalid_reg && out_stall;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_in == CMD_NUMBER && !err)
                begin
                    if (val_full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end
                    else
                        cmd.push_num = 1'b1;
                end
                else if (accept && cmd_in == CMD_OPER && !err && op_code == OP_OPEN)
                begin
                    if (op_full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_op = 1'b1;
                        cmd.op_val  = op_code;
                    end
                end
            end
            S_FINISH:
            begin
                if (!err && keep_reducing)
                begin
                    if (goal_reg == G_END && stat.top_op == OP_OPEN)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_PAREN;
                    end
                end
                else if (!err)
                begin
                    unique case (goal_reg)
                        G_ADDSUB, G_MULDIV:
                        begin
                            if (op_full)
                            begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_op = 1'b1;
                                cmd.op_val  = pend_reg;
                            end
                        end
                        G_CLOSE:
                        begin
                            if (stat.oper_count == '0)
                            begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = ST_PAREN;
                            end
                            else
                                cmd.pop_op = 1'b1;
                        end
                        default:
                        begin
                            if (stat.value_count != CNT_W'(1))
                            begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = ST_MISSING;
                            end
                        end
                    endcase
                end
            end
            S_REDUCE_RD:
            begin
                cmd.pop_op = 1'b1;
                if (stat.value_count < CNT_W'(2))
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_MISSING;
                end
                else
                    cmd.rd_vals = 1'b1;
            end
            S_REDUCE_EX:
            begin
                if (stat.div_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_DIVZERO;
                end
                else
                    cmd.start_ex = 1'b1;
            end
            S_DIV_WAIT:
                cmd = '0;
            S_REDUCE_WB:
                cmd.write_res = 1'b1;
            S_END_RD:
                cmd.rd_bottom = 1'b1;
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    out_load    = 1'b1;
                    ovalid_next = 1'b1;
                    cmd.clear   = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            goal_reg   <= G_ADDSUB;
            pend_reg   <= OP_ADD;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            goal_reg   <= goal_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== rtl/core/iee_checker.sv =====
// Checker: port-level properties of the evaluator, bound to the top level
module iee_checker
    import iee_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result,
    input logic [2:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_OVERFLOW)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result == 32'd0)
        else $error("non-zero result with error status");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown in reset");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .status    (status)
);

// ===== tb/infix_expression_evaluator_test.sv =====
// Testbench: token driver, two-stack expression predictor and result checker for the evaluator
module infix_expression_evaluator_test
    import iee_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] number;
        logic [2:0]  op_code;
    } token_t;

    typedef struct {
        logic [31:0] result;
        logic [2:0]  status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = CMD_NUMBER;
    logic signed [31:0] number = '0;
    logic [2:0] op_code = OP_ADD;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] result;
    logic [2:0] status;

    token_t  token_q[$];
    answer_t answer_q[$];
    int errors = 0;
    int sent = 0;
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;
    bit done_feeding = 1'b0;
    bit in_fire = 1'b0;

    logic [31:0] vals[STACK_DEPTH];
    int          nvals = 0;
    logic [2:0]  opers[STACK_DEPTH];
    int          nopers = 0;
    logic [2:0]  err = ST_OK;

    infix_expression_evaluator dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void raise(input logic [2:0] code);
        if (err == ST_OK)
            err = code;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (nvals >= STACK_DEPTH)
            raise(ST_OVERFLOW);
        else
        begin
            vals[nvals] = v;
            nvals++;
        end
    endfunction

    function automatic void push_oper(input logic [2:0] op);
        if (nopers >= STACK_DEPTH)
            raise(ST_OVERFLOW);
        else
        begin
            opers[nopers] = op;
            nopers++;
        end
    endfunction

    function automatic void apply_top_oper();
        logic [2:0] op;
        logic signed [31:0] lhs, rhs;
        logic [31:0] res;
        op = opers[nopers-1];
        nopers--;
        if (nvals < 2)
        begin
            raise(ST_MISSING);
            return;
        end
        rhs = vals[nvals-1];
        lhs = vals[nvals-2];
        nvals -= 2;
        case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default:
            begin
                if (rhs == 0)
                begin
                    raise(ST_DIVZERO);
                    return;
                end
                if (lhs == 32'sh8000_0000 && rhs == -1)
                    res = 32'h8000_0000;
                else
                    res = lhs / rhs;
            end
        endcase
        push_val(res);
    endfunction

    function automatic void evaluate_token(input token_t t);
        logic [2:0] op;
        answer_t a;
        op = t.op_code;
        if (t.cmd == CMD_NUMBER)
        begin
            if (err == ST_OK)
                push_val(t.number);
        end
        else if (t.cmd == CMD_OPER)
        begin
            if (err != ST_OK)
                return;
            if (op == OP_OPEN)
                push_oper(op);
            else if (op == OP_ADD || op == OP_SUB)
            begin
                while (err == ST_OK && nopers > 0 && opers[nopers-1] <= OP_DIV)
                    apply_top_oper();
                if (err == ST_OK)
                    push_oper(op);
            end
            else if (op == OP_MUL || op == OP_DIV)
            begin
                while (err == ST_OK && nopers > 0
                       && (opers[nopers-1] == OP_MUL || opers[nopers-1] == OP_DIV))
                    apply_top_oper();
                if (err == ST_OK)
                    push_oper(op);
            end
            else if (op == OP_CLOSE)
            begin
                while (err == ST_OK && nopers > 0 && opers[nopers-1] != OP_OPEN)
                    apply_top_oper();
                if (err == ST_OK)
                begin
                    if (nopers == 0)
                        raise(ST_PAREN);
                    else
                        nopers--;
                end
            end
        end
        else if (t.cmd == CMD_END)
        begin
            while (err == ST_OK && nopers > 0)
            begin
                if (opers[nopers-1] == OP_OPEN)
                    raise(ST_PAREN);
                else
                    apply_top_oper();
            end
            if (err == ST_OK && nvals != 1)
                raise(ST_MISSING);
            a.result = (err == ST_OK) ? vals[0] : 32'd0;
            a.status = err;
            answer_q = {answer_q, a};
            nvals = 0;
            nopers = 0;
            err = ST_OK;
        end
    endfunction

    function automatic logic [31:0] pick_number();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom;
            default: return $urandom_range(0, 40) - 20;
        endcase
    endfunction

    task automatic add_num(input logic [31:0] v);
        token_t t;
        t.cmd = CMD_NUMBER;
        t.number = v;
        t.op_code = 3'($urandom_range(0, 7));
        token_q = {token_q, t};
    endtask

    task automatic add_op(input logic [2:0] op);
        token_t t;
        t.cmd = CMD_OPER;
        t.number = $urandom;
        t.op_code = op;
        token_q = {token_q, t};
    endtask

    task automatic add_end();
        token_t t;
        t.cmd = CMD_END;
        t.number = $urandom;
        t.op_code = 3'($urandom_range(0, 7));
        token_q = {token_q, t};
    endtask

    task automatic add_raw();
        token_t t;
        t.cmd = 2'($urandom_range(0, 3));
        t.number = $urandom;
        t.op_code = 3'($urandom_range(0, 7));
        token_q = {token_q, t};
    endtask

    task automatic add_expression(input int terms);
        int depth;
        depth = 0;
        for (int i = 0; i < terms; i++)
        begin
            if (depth < 5 && $urandom_range(0, 4) == 0)
            begin
                add_op(OP_OPEN);
                depth++;
            end
            add_num(pick_number());
            if (depth > 0 && $urandom_range(0, 3) == 0)
            begin
                add_op(OP_CLOSE);
                depth--;
            end
            if (i < terms - 1)
                add_op(3'($urandom_range(0, 3)));
        end
        while (depth > 0)
        begin
            add_op(OP_CLOSE);
            depth--;
        end
        add_end();
    endtask

    task automatic wait_drained();
        while (token_q.size() != 0 || answer_q.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (token_q.size() != 0 && !($urandom_range(1, 100) <= send_idle))
                begin
                    token_t t;
                    t = token_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= t.cmd;
                    number <= t.number;
                    op_code <= t.op_code;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(1, 100) <= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            token_t t;
            t.cmd = cmd;
            t.number = number;
            t.op_code = op_code;
            evaluate_token(t);
            sent++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected result %0d status %0d", $time, result, status);
                errors++;
            end
            else
            begin
                answer_t a;
                a = answer_q.pop_front();
                if (result !== a.result || status !== a.status)
                begin
                    $display("%0t: expected %0d status %0d, got %0d status %0d",
                             $time, $signed(a.result), a.status, result, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: plain arithmetic, precedence, extremes, error cases
        add_num(7); add_op(OP_ADD); add_num(3); add_op(OP_MUL); add_num(4); add_end();
        add_num(20); add_op(OP_SUB); add_num(6); add_op(OP_SUB); add_num(4); add_end();
        add_op(OP_OPEN); add_num(-7); add_op(OP_ADD); add_num(2); add_op(OP_CLOSE);
        add_op(OP_DIV); add_num(2); add_end();
        add_num(32'h8000_0000); add_op(OP_DIV); add_num(32'hffff_ffff); add_end();
        add_num(32'h7fff_ffff); add_op(OP_MUL); add_num(32'h7fff_ffff); add_end();
        add_num(5); add_op(OP_DIV); add_num(0); add_num(1); add_end();
        add_num(1); add_op(OP_CLOSE); add_end();
        add_op(OP_OPEN); add_num(1); add_end();
        add_num(1); add_op(OP_ADD); add_end();
        add_end();
        add_num(1); add_num(2); add_end();
        add_num(3); add_op(3'd6); add_op(3'd7); add_end();
        begin
            token_t t;
            t.cmd = 2'd3; t.number = 32'hffff_ffff; t.op_code = 3'd7;
            token_q = {token_q, t};
        end
        for (int i = 0; i < 17; i++) add_num(i);
        add_end();
        for (int i = 0; i < 17; i++) add_op(OP_OPEN);
        add_num(1); add_end();
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                3: begin send_idle = 21; recv_stall = 21; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int n = 0; n < 280; )
            begin
                int before_n;
                before_n = token_q.size();
                case ($urandom_range(0, 9))
                    0: add_raw();
                    1: add_expression($urandom_range(9, 12));
                    default: add_expression($urandom_range(1, 5));
                endcase
                n += token_q.size() - before_n;
            end
            wait_drained();
        end
        done_feeding = 1'b1;
    end

    initial
    begin
        wait (done_feeding);
        repeat (100) @(posedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("infix_expression_evaluator_test: done, clean");
        else
            $display("infix_expression_evaluator_test: done, errors");
        $finish;
    end

    initial
    begin
        wait (cycles >= 400000);
        $display("infix_expression_evaluator_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/iee_pkg.sv
rtl/core/iee_divider.sv
rtl/core/iee_datapath.sv
rtl/core/iee_control.sv
rtl/core/infix_expression_evaluator.sv
rtl/core/iee_checker.sv
tb/infix_expression_evaluator_test.sv
